[design/als_pkg.sv]
// Package: shared types, register indexes, codes and time helpers for the light sample sequencer.
`default_nettype none

package als_pkg;

    // Width of the tick counter and of every deadline
    localparam int TIME_WIDTH = 32;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_TICKS           = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MEASURE_WAIT_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SAMPLE_PERIOD_TICKS = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEVICE_ADDRESS      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POWER_ON_COMMAND    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESET_COMMAND       = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MEASURE_COMMAND     = 3'd6;

    // Register reset values
    localparam logic [15:0] GAP_TICKS_RST           = 16'd10;
    localparam logic [15:0] MEASURE_WAIT_TICKS_RST  = 16'd180;
    localparam logic [15:0] SAMPLE_PERIOD_TICKS_RST = 16'd300;
    localparam logic [7:0]  DEVICE_ADDRESS_RST      = 8'd70;
    localparam logic [7:0]  POWER_ON_COMMAND_RST    = 8'd1;
    localparam logic [7:0]  RESET_COMMAND_RST       = 8'd7;
    localparam logic [7:0]  MEASURE_COMMAND_RST     = 8'd32;

    // Input function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_GET  = 1'b1;

    // Bus operation codes
    localparam logic [1:0] BUS_OP_NONE  = 2'd0;
    localparam logic [1:0] BUS_OP_WRITE = 2'd1;
    localparam logic [1:0] BUS_OP_READ  = 2'd2;

    // Phase codes as reported on the result channel
    localparam logic [2:0] PHASE_IDLE    = 3'd0;
    localparam logic [2:0] PHASE_ON      = 3'd1;
    localparam logic [2:0] PHASE_RESET   = 3'd2;
    localparam logic [2:0] PHASE_MEASURE = 3'd3;
    localparam logic [2:0] PHASE_WAIT    = 3'd4;
    localparam logic [2:0] PHASE_READ    = 3'd5;
    localparam logic [2:0] PHASE_CONVERT = 3'd6;
    localparam logic [2:0] PHASE_DONE    = 3'd7;

    // raw*10/12 = floor(5*raw/6); divide by 6 as multiply by ceil(2^20/6), exact below 2^19
    localparam int          LUX_SHIFT = 20;
    localparam logic [17:0] LUX_RECIP = 18'd174763;

    typedef struct packed {
        logic        func;
        logic        bus_ok;
        logic [15:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  bus_op;
        logic [7:0]  bus_address;
        logic [7:0]  bus_command;
        logic [15:0] lux;
        logic        ready_res;
        logic [2:0]  phase;
    } out_item_t;

    typedef struct packed {
        logic [15:0] gap_ticks;
        logic [15:0] measure_wait_ticks;
        logic [15:0] sample_period_ticks;
        logic [7:0]  device_address;
        logic [7:0]  power_on_command;
        logic [7:0]  reset_command;
        logic [7:0]  measure_command;
    } cfg_t;

    typedef logic [TIME_WIDTH-1:0] time_t;

    // A time is reached when (now - when) mod 2^TIME_WIDTH is in the lower half
    function automatic logic reached(input time_t now, input time_t when);
        time_t diff;
        diff = now - when;
        return !diff[TIME_WIDTH-1];
    endfunction

    function automatic time_t later(input time_t now, input logic [15:0] delta);
        time_t ext;
        ext = time_t'(delta);
        return now + ext;
    endfunction

endpackage

`default_nettype wire

[design/als_cfg.sv]
// Configuration register file of the light sample sequencer.
`default_nettype none

module als_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [als_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [als_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output als_pkg::cfg_t                            cfg
);

    als_pkg::cfg_t cfg_reg;
    als_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                als_pkg::CFG_GAP_TICKS:           cfg_next.gap_ticks = cfg_wdata;
                als_pkg::CFG_MEASURE_WAIT_TICKS:  cfg_next.measure_wait_ticks = cfg_wdata;
                als_pkg::CFG_SAMPLE_PERIOD_TICKS: cfg_next.sample_period_ticks = cfg_wdata;
                als_pkg::CFG_DEVICE_ADDRESS:      cfg_next.device_address = cfg_wdata[7:0];
                als_pkg::CFG_POWER_ON_COMMAND:    cfg_next.power_on_command = cfg_wdata[7:0];
                als_pkg::CFG_RESET_COMMAND:       cfg_next.reset_command = cfg_wdata[7:0];
                als_pkg::CFG_MEASURE_COMMAND:     cfg_next.measure_command = cfg_wdata[7:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_ticks           <= als_pkg::GAP_TICKS_RST;
            cfg_reg.measure_wait_ticks  <= als_pkg::MEASURE_WAIT_TICKS_RST;
            cfg_reg.sample_period_ticks <= als_pkg::SAMPLE_PERIOD_TICKS_RST;
            cfg_reg.device_address      <= als_pkg::DEVICE_ADDRESS_RST;
            cfg_reg.power_on_command    <= als_pkg::POWER_ON_COMMAND_RST;
            cfg_reg.reset_command       <= als_pkg::RESET_COMMAND_RST;
            cfg_reg.measure_command     <= als_pkg::MEASURE_COMMAND_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/als_seq.sv]
// Sequence state and per-item step logic of the light sample sequencer.
`default_nettype none

module als_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire als_pkg::in_item_t item,
    input  wire als_pkg::cfg_t     cfg,
    output als_pkg::out_item_t     result
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_ON      = 9'b000000010,
        ST_RESET   = 9'b000000100,
        ST_MEASURE = 9'b000001000,
        ST_WAIT    = 9'b000010000,
        ST_READ    = 9'b000100000,
        ST_CONVERT = 9'b001000000,
        ST_DONE    = 9'b010000000,
        ST_ERROR   = 9'b100000000
    } seq_state_t;

    seq_state_t     state_reg, state_next, cur_state;
    als_pkg::time_t tick_reg, tick_next;
    als_pkg::time_t deadline_reg, deadline_next, cur_deadline;
    als_pkg::time_t next_sample_reg, next_sample_next;
    logic           ready_reg, ready_next;
    logic [15:0]    raw_reg, raw_next;
    logic [15:0]    lux_reg, lux_next;
    als_pkg::time_t now;
    logic           run;
    logic [18:0]    raw_x5;
    logic [36:0]    lux_prod;
    logic [2:0]     phase_code;
    logic [1:0]     bus_op;
    logic [7:0]     bus_address;
    logic [7:0]     bus_command;

    // 5*raw, then divide by 6 through the reciprocal
    assign raw_x5   = {1'b0, raw_reg, 2'b00} + {3'b000, raw_reg};
    assign lux_prod = 37'(raw_x5) * 37'(als_pkg::LUX_RECIP);

    always_comb begin
        state_next       = state_reg;
        tick_next        = tick_reg;
        deadline_next    = deadline_reg;
        next_sample_next = next_sample_reg;
        ready_next       = ready_reg;
        raw_next         = raw_reg;
        lux_next         = lux_reg;
        bus_op           = als_pkg::BUS_OP_NONE;
        bus_address      = 8'd0;
        bus_command      = 8'd0;
        now          = tick_reg;
        run          = 1'b0;
        cur_state    = state_reg;
        cur_deadline = deadline_reg;

        if (item.func == als_pkg::FUNC_GET) begin
            ready_next = 1'b0;
        end else begin
            tick_next = tick_reg + als_pkg::time_t'(1);
            run       = 1'b1;
            if (state_reg == ST_IDLE) begin
                if (als_pkg::reached(now, next_sample_reg)) begin
                    // start the sample; power-on write runs in this same tick
                    cur_state     = ST_ON;
                    cur_deadline  = now;
                    state_next    = ST_ON;
                    deadline_next = now;
                end else begin
                    run = 1'b0;
                end
            end
            if (run && als_pkg::reached(now, cur_deadline)) begin
                unique case (cur_state)
                    ST_ON, ST_RESET, ST_MEASURE: begin
                        bus_op      = als_pkg::BUS_OP_WRITE;
                        bus_address = cfg.device_address;
                        if (cur_state == ST_ON) begin
                            bus_command = cfg.power_on_command;
                        end else if (cur_state == ST_RESET) begin
                            bus_command = cfg.reset_command;
                        end else begin
                            bus_command = cfg.measure_command;
                        end
                        if (!item.bus_ok) begin
                            state_next = ST_ERROR;
                        end else if (cur_state == ST_ON) begin
                            state_next    = ST_RESET;
                            deadline_next = als_pkg::later(now, cfg.gap_ticks);
                        end else if (cur_state == ST_RESET) begin
                            state_next    = ST_MEASURE;
                            deadline_next = als_pkg::later(now, cfg.gap_ticks);
                        end else begin
                            state_next    = ST_WAIT;
                            deadline_next = als_pkg::later(now, cfg.measure_wait_ticks);
                        end
                    end
                    ST_WAIT: begin
                        state_next    = ST_READ;
                        deadline_next = now;
                    end
                    ST_READ: begin
                        bus_op      = als_pkg::BUS_OP_READ;
                        bus_address = cfg.device_address + 8'd1;
                        if (!item.bus_ok) begin
                            state_next = ST_ERROR;
                        end else begin
                            raw_next      = item.read_data;
                            state_next    = ST_CONVERT;
                            deadline_next = now;
                        end
                    end
                    ST_CONVERT: begin
                        lux_next      = lux_prod[als_pkg::LUX_SHIFT +: 16];
                        state_next    = ST_DONE;
                        deadline_next = now;
                    end
                    ST_DONE: begin
                        ready_next       = 1'b1;
                        next_sample_next = als_pkg::later(now, cfg.sample_period_ticks);
                        state_next       = ST_IDLE;
                    end
                    ST_ERROR: begin
                        // retry one period later
                        ready_next       = 1'b0;
                        next_sample_next = als_pkg::later(now, cfg.sample_period_ticks);
                        state_next       = ST_IDLE;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (state_next)
            ST_ON:      phase_code = als_pkg::PHASE_ON;
            ST_RESET:   phase_code = als_pkg::PHASE_RESET;
            ST_MEASURE: phase_code = als_pkg::PHASE_MEASURE;
            ST_WAIT:    phase_code = als_pkg::PHASE_WAIT;
            ST_READ:    phase_code = als_pkg::PHASE_READ;
            ST_CONVERT: phase_code = als_pkg::PHASE_CONVERT;
            ST_DONE:    phase_code = als_pkg::PHASE_DONE;
            default:    phase_code = als_pkg::PHASE_IDLE; // idle and error
        endcase
    end

    assign result = '{
        bus_op:      bus_op,
        bus_address: bus_address,
        bus_command: bus_command,
        lux:         lux_next,
        ready_res:   ready_next,
        phase:       phase_code
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            tick_reg        <= '0;
            deadline_reg    <= '0;
            next_sample_reg <= '0;
            ready_reg       <= 1'b0;
            raw_reg         <= 16'd0;
            lux_reg         <= 16'd0;
        end else if (step_en) begin
            state_reg       <= state_next;
            tick_reg        <= tick_next;
            deadline_reg    <= deadline_next;
            next_sample_reg <= next_sample_next;
            ready_reg       <= ready_next;
            raw_reg         <= raw_next;
            lux_reg         <= lux_next;
        end
    end

endmodule

`default_nettype wire

[design/ambient_light_sample_sequencer_top.sv]
// Top level of the ambient light sample sequencer: input stage, step logic and result register.
//
// Each transaction on the s_ channel is either a tick (func 0), which runs at most one step of the
// sensor poll sequence (power-on, reset and measure command writes, a wait, a two-byte read,
// conversion to lux as raw*10/12, done), or a get (func 1), which returns the last lux value and
// clears the ready flag. Every input transaction produces exactly one m_ transaction that names
// the bus operation for that tick, the current lux, the ready flag and the phase after the step.
// A failed bus operation (bus_ok low on a tick that issued one) sends the sequence to an error
// step that clears ready and schedules a retry one sample period later; the phase reads idle
// while in error. Deadlines are kept against a 32-bit tick count and compared wrap-safe.
// Throughput is one transaction per clock while m_ready stays high: the item is registered at
// the input, one step of compare, add and a single small multiply (the divide by six) runs
// once the result register is empty or being drained, and the result lands in the output
// register, which drives m_valid and m_data. While m_ready is low the result register holds,
// and once the input stage is full too s_ready drops. The user must write registers over the
// cfg_ port only while no transaction is in flight; the block itself does not enforce this.
`default_nettype none

module ambient_light_sample_sequencer_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire als_pkg::in_item_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output als_pkg::out_item_t                       m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [als_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [als_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    als_pkg::cfg_t      cfg;
    als_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    als_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    als_pkg::out_item_t step_result;
    logic               advance;

    // Advance the input stage whenever the result register is empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // Take a new transaction while the held one moves on, so ticks stream back to back
    assign s_ready = !in_valid_reg || advance;

    als_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequence state commits only when the step result is captured
    als_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Input stage: hold the accepted item until its step runs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Result register: hold the result until the m_ side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
